// File: sv/qtg_pkg.sv
// shared types and constants for the quintic trajectory generator
`default_nettype none

package qtg_pkg;

  localparam int AXES    = 4;
  localparam int AXIS_W  = $clog2(AXES);
  localparam int ANGLE_W = 24;
  localparam int TICKS_W = 16;
  localparam int LIMIT_W = 23;
  localparam int CFG_W   = 23;
  localparam int REG_W   = 2;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_ENABLE      = 2'd0;
  localparam logic [REG_W-1:0] REG_MOVE_TICKS  = 2'd1;
  localparam logic [REG_W-1:0] REG_ANGLE_LIMIT = 2'd2;

  // register reset values
  localparam logic [TICKS_W-1:0] MOVE_TICKS_RST  = 16'd2000;
  localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST = 23'd183347;

  typedef struct packed {
    logic [1:0]                action;
    logic                      link_ok;
    logic signed [ANGLE_W-1:0] goal_a;
    logic signed [ANGLE_W-1:0] goal_b;
    logic signed [ANGLE_W-1:0] goal_c;
    logic signed [ANGLE_W-1:0] goal_d;
  } item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] cmd_a;
    logic signed [ANGLE_W-1:0] cmd_b;
    logic signed [ANGLE_W-1:0] cmd_c;
    logic signed [ANGLE_W-1:0] cmd_d;
    logic                      cmd_fresh;
    logic                      moving;
    logic                      outcome;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic              latch_start;
    logic              clear_run;
    logic              tick;
    logic              div_step;
    logic              square;
    logic              cube;
    logic              blend;
    logic              ax_diff;
    logic              ax_mul;
    logic              ax_add;
    logic [AXIS_W-1:0] axis;
    logic              load_result;
    logic              fresh;
    logic              rejected;
  } qtg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enable;
    logic running;
    logic limit_ok;
    logic tick_end;
  } qtg_status_t;

endpackage

`default_nettype wire

// File: sv/qtg_ctrl.sv
// sequencing state machine for the quintic trajectory generator
`default_nettype none

module qtg_ctrl #(
  parameter int PROGRESS_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic [1:0]          item_action,
  input  wire logic                item_link_ok,
  output logic                     result_valid,
  input  wire logic                result_stall,
  input  wire qtg_pkg::qtg_status_t status,
  output qtg_pkg::qtg_cmd_t        cmd
);

  localparam int CW = $clog2(PROGRESS_BITS);
  localparam int AXW = qtg_pkg::AXIS_W;
  localparam logic [CW-1:0] DIV_LAST = CW'(PROGRESS_BITS - 1);
  localparam logic [AXW-1:0] AXIS_LAST = AXW'(qtg_pkg::AXES - 1);

  typedef enum logic [3:0] {
    IDLE, DIV, SQUARE, CUBE, BLEND, AX_DIFF, AX_MUL, AX_ADD, FINISH
  } state_t;

  state_t                      state;
  logic [CW-1:0]               div_cnt;
  logic [qtg_pkg::AXIS_W-1:0]  axis;
  logic                        fresh;
  logic                        rejected;
  logic                        slot_free;
  logic                        accept;

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && (state == IDLE);
  assign slot_free  = !result_valid || !result_stall;

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.fresh       = fresh;
    cmd.rejected    = rejected;
    if (accept) begin
      unique case (item_action)
        qtg_pkg::ACT_START: begin
          cmd.latch_start = status.enable && item_link_ok && status.limit_ok;
        end
        qtg_pkg::ACT_STOP: begin
          cmd.clear_run = status.enable;
        end
        qtg_pkg::ACT_TICK: begin
          cmd.clear_run = status.enable && !item_link_ok;
          cmd.tick      = status.enable && item_link_ok && status.running;
        end
        default: begin
        end
      endcase
    end
    unique case (state)
      DIV:     cmd.div_step    = 1'b1;
      SQUARE:  cmd.square      = 1'b1;
      CUBE:    cmd.cube        = 1'b1;
      BLEND:   cmd.blend       = 1'b1;
      AX_DIFF: cmd.ax_diff     = 1'b1;
      AX_MUL:  cmd.ax_mul      = 1'b1;
      AX_ADD:  cmd.ax_add      = 1'b1;
      FINISH:  cmd.load_result = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      div_cnt      <= '0;
      axis         <= '0;
      fresh        <= 1'b0;
      rejected     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            fresh    <= cmd.tick;
            rejected <= (item_action == qtg_pkg::ACT_START) && !cmd.latch_start;
            div_cnt  <= '0;
            axis     <= '0;
            if (cmd.tick) begin
              state <= status.tick_end ? SQUARE : DIV;
            end else begin
              state <= FINISH;
            end
          end
        end
        DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            state <= SQUARE;
          end
        end
        SQUARE:  state <= CUBE;
        CUBE:    state <= BLEND;
        BLEND:   state <= AX_DIFF;
        AX_DIFF: state <= AX_MUL;
        AX_MUL:  state <= AX_ADD;
        AX_ADD: begin
          axis <= axis + 1'b1;
          if (axis == AXIS_LAST) begin
            state <= FINISH;
          end else begin
            state <= AX_DIFF;
          end
        end
        FINISH: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/qtg_datapath.sv
// registers, progress divider and blend arithmetic of the trajectory generator
`default_nettype none

module qtg_datapath #(
  parameter int PROGRESS_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [qtg_pkg::REG_W-1:0]       cfg_index,
  input  wire logic [qtg_pkg::CFG_W-1:0]       cfg_data,
  input  wire qtg_pkg::item_t                  item,
  input  wire qtg_pkg::qtg_cmd_t               cmd,
  output qtg_pkg::qtg_status_t                 status,
  output qtg_pkg::result_t                     result
);

  localparam int P  = PROGRESS_BITS;
  localparam int PW = P + 1;
  localparam int IW = P + 4;
  localparam int DW = P + 27;
  localparam int AW = qtg_pkg::ANGLE_W;
  localparam int TW = qtg_pkg::TICKS_W;

  localparam logic [PW-1:0]  ONE     = {1'b1, {P{1'b0}}};
  localparam logic [P+4:0]   TEN_ONE = {1'b0, 4'b1010, {P{1'b0}}};
  localparam logic [DW-1:0]  HALF    = {{(DW-P){1'b0}}, 1'b1, {(P-1){1'b0}}};

  // configuration
  logic                        enable;
  logic [TW-1:0]               move_ticks;
  logic [qtg_pkg::LIMIT_W-1:0] angle_limit;

  // move state
  logic signed [AW-1:0] start_pos   [qtg_pkg::AXES];
  logic signed [AW-1:0] goal_pos    [qtg_pkg::AXES];
  logic signed [AW-1:0] command_pos [qtg_pkg::AXES];
  logic signed [AW-1:0] goal_in     [qtg_pkg::AXES];
  logic [TW-1:0]        elapsed;
  logic                 running;

  // arithmetic
  logic [TW-1:0]        elapsed_next;
  logic [TW-1:0]        rem;
  logic [TW:0]          rem_shift;
  logic                 rem_ge;
  logic [PW-1:0]        p;
  logic [PW-1:0]        p2;
  logic [PW-1:0]        p3;
  logic [IW-1:0]        inner;
  logic [P+4:0]         inner_sum;
  logic [PW-1:0]        blend;
  logic [2*PW-1:0]      sq_prod;
  logic [2*PW-1:0]      cube_prod;
  logic [PW+IW-1:0]     bl_prod;
  logic signed [AW:0]   diff;
  logic signed [DW-1:0] ax_prod;
  logic signed [DW-1:0] prod;
  logic [DW-1:0]        rounded;
  logic [DW-P-1:0]      step;
  logic [DW-P-1:0]      cmd_sum;

  // limit check on axes three and four
  logic signed [AW:0]   lim;
  logic signed [AW:0]   goal_c_ext;
  logic signed [AW:0]   goal_d_ext;

  always_comb begin
    goal_in[0] = item.goal_a;
    goal_in[1] = item.goal_b;
    goal_in[2] = item.goal_c;
    goal_in[3] = item.goal_d;
  end

  assign lim        = $signed({2'b00, angle_limit});
  assign goal_c_ext = {item.goal_c[AW-1], item.goal_c};
  assign goal_d_ext = {item.goal_d[AW-1], item.goal_d};

  assign elapsed_next = (elapsed == {TW{1'b1}}) ? elapsed : elapsed + 1'b1;

  assign status.enable   = enable;
  assign status.running  = running;
  assign status.limit_ok = (goal_c_ext <= lim) && (goal_c_ext >= -lim) &&
                           (goal_d_ext <= lim) && (goal_d_ext >= -lim);
  assign status.tick_end = (elapsed_next >= move_ticks);

  // restoring division, one quotient bit per cycle
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, move_ticks});

  // polynomial terms
  assign sq_prod   = p * p;
  assign cube_prod = p2 * p;
  assign inner_sum = TEN_ONE + {2'b00, p2, 2'b00} + {3'b000, p2, 1'b0}
                     - {p, 4'b0000} + {4'b0000, p};
  assign bl_prod   = p3 * inner;

  // per-axis interpolation
  assign ax_prod = diff * $signed({1'b0, blend});
  assign rounded = prod + HALF;
  assign step    = rounded[DW-1:P];
  assign cmd_sum = {{(DW-P-AW){start_pos[cmd.axis][AW-1]}}, start_pos[cmd.axis]} + step;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      move_ticks  <= qtg_pkg::MOVE_TICKS_RST;
      angle_limit <= qtg_pkg::ANGLE_LIMIT_RST;
      elapsed     <= '0;
      running     <= 1'b0;
      for (int i = 0; i < qtg_pkg::AXES; i++) begin
        start_pos[i]   <= '0;
        goal_pos[i]    <= '0;
        command_pos[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          qtg_pkg::REG_ENABLE:      enable      <= cfg_data[0];
          qtg_pkg::REG_MOVE_TICKS:  move_ticks  <= cfg_data[TW-1:0];
          qtg_pkg::REG_ANGLE_LIMIT: angle_limit <= cfg_data[qtg_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.latch_start) begin
        for (int i = 0; i < qtg_pkg::AXES; i++) begin
          start_pos[i] <= command_pos[i];
          goal_pos[i]  <= goal_in[i];
        end
        elapsed <= '0;
        running <= 1'b1;
      end
      if (cmd.clear_run) begin
        running <= 1'b0;
      end
      if (cmd.tick) begin
        elapsed <= elapsed_next;
        if (status.tick_end) begin
          running <= 1'b0;
        end
      end
      if (cmd.ax_add) begin
        command_pos[cmd.axis] <= cmd_sum[AW-1:0];
      end
    end
  end

  // arithmetic registers need no reset
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      rem <= elapsed_next;
      p   <= status.tick_end ? ONE : '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? TW'(rem_shift - {1'b0, move_ticks}) : rem_shift[TW-1:0];
      p   <= {p[PW-2:0], rem_ge};
    end
    if (cmd.square) begin
      p2 <= sq_prod[2*P:P];
    end
    if (cmd.cube) begin
      p3    <= cube_prod[2*P:P];
      inner <= inner_sum[IW-1:0];
    end
    if (cmd.blend) begin
      blend <= bl_prod[2*P:P];
    end
    if (cmd.ax_diff) begin
      diff <= {goal_pos[cmd.axis][AW-1], goal_pos[cmd.axis]}
              - {start_pos[cmd.axis][AW-1], start_pos[cmd.axis]};
    end
    if (cmd.ax_mul) begin
      prod <= ax_prod;
    end
    if (cmd.load_result) begin
      result.cmd_a     <= command_pos[0];
      result.cmd_b     <= command_pos[1];
      result.cmd_c     <= command_pos[2];
      result.cmd_d     <= command_pos[3];
      result.cmd_fresh <= cmd.fresh;
      result.moving    <= running;
      result.outcome   <= cmd.rejected;
    end
  end

endmodule

`default_nettype wire

// File: sv/quintic_trajectory_generator.sv
// top level of the four-axis minimum-jerk quintic setpoint generator
`default_nettype none

// Four-axis minimum-jerk setpoint generator. Each input word carries an
// action (tick, start, stop), the link state and four target angles in
// signed 1/256 degree; each input word yields exactly one result word with
// the four commanded angles and the fresh, moving and outcome flags. A tick
// during a move goes from acceptance to the result register through the
// one-bit-per-cycle progress divider, three polynomial steps (square, cube,
// blend), three steps per axis on the interpolation multiplier (difference,
// multiply, add), then the FINISH state, which loads the result register
// once the output slot is free; the next word can be taken after that load.
// The last tick of a move skips the divider. Every other word goes straight
// to FINISH. One word is worked on at a time; the next word is taken while a
// finished result still waits in the output register. Configuration is
// written through cfg_we / cfg_index / cfg_data; the user must write it only
// while the block is idle (the block itself does not enforce this);
// index 0 enable, 1 move_ticks, 2 angle_limit.
module quintic_trajectory_generator #(
  parameter int PROGRESS_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [qtg_pkg::REG_W-1:0]     cfg_index,
  input  wire logic [qtg_pkg::CFG_W-1:0]     cfg_data,
  // input words
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire qtg_pkg::item_t                item,
  // result words
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output qtg_pkg::result_t                   result
);

  // command and status between sequencer and datapath
  qtg_pkg::qtg_cmd_t    cmd;
  qtg_pkg::qtg_status_t status;

  // sequencer: decides what each word does and steps the arithmetic
  qtg_ctrl #(
    .PROGRESS_BITS (PROGRESS_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_action  (item.action),
    .item_link_ok (item.link_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath: config, move state, divider, multipliers, output register
  qtg_datapath #(
    .PROGRESS_BITS (PROGRESS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for the quintic trajectory generator
`default_nettype none

module tb;
  import qtg_pkg::*;

  localparam int PROG_BITS = 16;
  // action code that the block ignores
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 23'h7FFFFF;
  // extra wait in drain once every predicted word has come back
  localparam int SETTLE = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 900;
  localparam int LIMIT_TIME = 4000000;

  // predicts each result word from the accepted input words and checks it
  class setpoint_scoreboard;
    logic                      en_r;
    logic [TICKS_W-1:0]        ticks_r;
    logic [LIMIT_W-1:0]        limit_r;
    logic signed [ANGLE_W-1:0] start_pos[AXES];
    logic signed [ANGLE_W-1:0] goal_pos[AXES];
    logic signed [ANGLE_W-1:0] command_pos[AXES];
    logic [TICKS_W-1:0]        elapsed;
    logic                      running;
    result_t                   expected_setpoints[$];
    int                        errors;

    function new();
      en_r    = 1'b0;
      ticks_r = MOVE_TICKS_RST;
      limit_r = ANGLE_LIMIT_RST;
      for (int i = 0; i < AXES; i++) begin
        start_pos[i]   = '0;
        goal_pos[i]    = '0;
        command_pos[i] = '0;
      end
      elapsed = '0;
      running = 1'b0;
      errors  = 0;
    endfunction

    function void set_reg(logic [REG_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ENABLE:      en_r = data[0];
        REG_MOVE_TICKS:  ticks_r = data[TICKS_W-1:0];
        REG_ANGLE_LIMIT: limit_r = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // one tick of a running move: progress, quintic blend, per-axis interpolation
    function void advance_move();
      longint unsigned one, p, p2, p3, inner, blend;
      longint diff, acc;
      one = 64'd1 << PROG_BITS;
      if (elapsed != '1) elapsed++;
      if (elapsed >= ticks_r) begin
        p = one;
        running = 1'b0;
      end else begin
        p = (longint'(elapsed) << PROG_BITS) / longint'(ticks_r);
      end
      p2 = (p * p) >> PROG_BITS;
      p3 = (p2 * p) >> PROG_BITS;
      inner = 10 * one + 6 * p2 - 15 * p;
      blend = (p3 * inner) >> PROG_BITS;
      for (int i = 0; i < AXES; i++) begin
        diff = longint'(goal_pos[i]) - longint'(start_pos[i]);
        // round to nearest, ties up, then floor via arithmetic shift
        acc = diff * longint'(blend) + longint'(one >> 1);
        command_pos[i] = ANGLE_W'(longint'(start_pos[i]) + (acc >>> PROG_BITS));
      end
    endfunction

    function void note_word(item_t w);
      result_t e;
      longint  c, d, lim;
      logic    fresh, rejected;
      fresh = 1'b0;
      rejected = 1'b0;
      case (w.action)
        ACT_START: begin
          c = longint'(w.goal_c);
          d = longint'(w.goal_d);
          lim = longint'(limit_r);
          if (en_r && w.link_ok && c <= lim && c >= -lim && d <= lim && d >= -lim) begin
            for (int i = 0; i < AXES; i++) start_pos[i] = command_pos[i];
            goal_pos[0] = w.goal_a;
            goal_pos[1] = w.goal_b;
            goal_pos[2] = w.goal_c;
            goal_pos[3] = w.goal_d;
            elapsed = '0;
            running = 1'b1;
          end else begin
            rejected = 1'b1;
          end
        end
        ACT_STOP: begin
          if (en_r) running = 1'b0;
        end
        ACT_TICK: begin
          if (en_r) begin
            if (!w.link_ok) begin
              running = 1'b0;
            end else if (running) begin
              advance_move();
              fresh = 1'b1;
            end
          end
        end
        default: ;
      endcase
      e.cmd_a     = command_pos[0];
      e.cmd_b     = command_pos[1];
      e.cmd_c     = command_pos[2];
      e.cmd_d     = command_pos[3];
      e.cmd_fresh = fresh;
      e.moving    = running;
      e.outcome   = rejected;
      expected_setpoints.push_back(e);
    endfunction

    function void field_ok(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(result_t r);
      result_t e;
      if (expected_setpoints.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, r);
        errors++;
        return;
      end
      e = expected_setpoints.pop_front();
      field_ok("cmd_a", longint'(e.cmd_a), longint'(r.cmd_a));
      field_ok("cmd_b", longint'(e.cmd_b), longint'(r.cmd_b));
      field_ok("cmd_c", longint'(e.cmd_c), longint'(r.cmd_c));
      field_ok("cmd_d", longint'(e.cmd_d), longint'(r.cmd_d));
      field_ok("cmd_fresh", longint'(e.cmd_fresh), longint'(r.cmd_fresh));
      field_ok("moving", longint'(e.moving), longint'(r.moving));
      field_ok("outcome", longint'(e.outcome), longint'(r.outcome));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_W-1:0]     cfg_index = REG_ENABLE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  setpoint_scoreboard   sb = new();
  int                   send_idle_pct = 38;
  int                   recv_idle_pct = 55;
  int                   result_count = 0;
  int                   hold_left = 0;
  bit                   held_once = 1'b0;

  quintic_trajectory_generator #(
    .PROGRESS_BITS(PROG_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver side: random stall, plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (!held_once && result_count >= HOLD_AT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // every accepted result word is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_word(result);
      result_count <= result_count + 1;
    end
  end

  // safety net in case the block hangs
  initial begin
    #(LIMIT_TIME);
    $display("tb: FAIL");
    $finish;
  end

  function automatic item_t word(logic [1:0] act, logic link,
                                 logic signed [ANGLE_W-1:0] a, logic signed [ANGLE_W-1:0] b,
                                 logic signed [ANGLE_W-1:0] c, logic signed [ANGLE_W-1:0] d);
    item_t w;
    w.action  = act;
    w.link_ok = link;
    w.goal_a  = a;
    w.goal_b  = b;
    w.goal_c  = c;
    w.goal_d  = d;
    return w;
  endfunction

  // full-range angle with the extremes showing up often
  function automatic logic signed [ANGLE_W-1:0] any_angle();
    case ($urandom_range(15))
      0: return ANGLE_MAX;
      1: return ANGLE_MIN;
      2: return '0;
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  // angle that passes the current limit check, edges included
  function automatic logic signed [ANGLE_W-1:0] legal_angle();
    longint      lim;
    int unsigned span;
    lim = longint'(sb.limit_r);
    span = 2 * sb.limit_r;
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? ANGLE_W'(lim) : ANGLE_W'(-lim);
    return ANGLE_W'(longint'($urandom_range(span)) - lim);
  endfunction

  function automatic item_t start_word();
    return word(ACT_START, 1'b1, any_angle(), any_angle(), legal_angle(), legal_angle());
  endfunction

  function automatic item_t tick_word(logic link);
    return word(ACT_TICK, link, any_angle(), any_angle(), any_angle(), any_angle());
  endfunction

  // offer one word, idling at random first; returns on the falling edge after acceptance
  task automatic send_word(input item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input logic en, input logic [TICKS_W-1:0] ticks,
                            input logic [LIMIT_W-1:0] lim);
    write_reg(REG_ENABLE, CFG_W'(en));
    write_reg(REG_MOVE_TICKS, CFG_W'(ticks));
    write_reg(REG_ANGLE_LIMIT, CFG_W'(lim));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every predicted word has come back and the block is quiet
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_setpoints.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly complete moves with random content, some interruptions and noise
  task automatic run_moves(input int n);
    int    sent;
    int    span;
    int    r;
    item_t w;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 75) begin
        send_word(start_word());
        sent++;
        span = (sb.ticks_r > 12) ? $urandom_range(12, 1) : sb.ticks_r + $urandom_range(2);
        for (int k = 0; k < span && sent < n; k++) begin
          r = $urandom_range(99);
          if (r < 3)
            w = tick_word(1'b0);
          else if (r < 6)
            w = word(ACT_STOP, 1'($urandom_range(1)), any_angle(), any_angle(),
                     any_angle(), any_angle());
          else if (r < 9)
            w = start_word();
          else
            w = tick_word(1'b1);
          send_word(w);
          sent++;
        end
      end else begin
        // noise: any action, mostly out-of-limit goals, link sometimes down
        w = word(2'($urandom_range(3)), ($urandom_range(9) != 0), any_angle(), any_angle(),
                 any_angle(), any_angle());
        send_word(w);
        if (w.action != ACT_SPARE) sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: disabled, so nothing moves and starts bounce
    send_word(word(ACT_TICK, 1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    send_word(word(ACT_START, 1'b1, 24'sd100, 24'sd200, 24'sd300, 24'sd400));
    send_word(word(ACT_STOP, 1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    send_word(word(ACT_SPARE, 1'b1, 24'sd5, 24'sd6, 24'sd7, 24'sd8));
    drain();

    // widest limit: full-scale move across the extremes
    set_config(1'b1, 16'd4, LIMIT_MAX);
    send_word(word(ACT_START, 1'b1, ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, -ANGLE_MAX));
    repeat (4) send_word(tick_word(1'b1));
    send_word(tick_word(1'b1));   // idle tick, nothing fresh
    // most negative goal is beyond any limit
    send_word(word(ACT_START, 1'b1, 24'sd1, 24'sd2, ANGLE_MIN, 24'sd0));
    send_word(word(ACT_START, 1'b0, 24'sd1, 24'sd2, 24'sd3, 24'sd4));   // link down
    send_word(word(ACT_START, 1'b1, -24'sd1000, 24'sd5000, 24'sd7, -24'sd7));
    send_word(tick_word(1'b1));
    send_word(tick_word(1'b0));   // link drops mid move, commands held
    send_word(word(ACT_START, 1'b1, 24'sd4000, -24'sd4000, 24'sd1, -24'sd1));
    send_word(tick_word(1'b1));
    // restart from where the move got to
    send_word(word(ACT_START, 1'b1, -24'sd300000, 24'sd300000, -24'sd9, 24'sd9));
    send_word(tick_word(1'b1));
    send_word(word(ACT_STOP, 1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    send_word(word(ACT_SPARE, 1'b0, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN));
    drain();

    // zero duration and zero limit
    set_config(1'b1, 16'd0, 23'd0);
    send_word(word(ACT_START, 1'b1, 24'sd123456, -24'sd654321, 24'sd0, 24'sd0));
    send_word(tick_word(1'b1));   // done on the first tick
    send_word(word(ACT_START, 1'b1, 24'sd10, 24'sd10, 24'sd1, 24'sd0));
    drain();

    // sender idles less than receiver
    set_config(1'b1, 16'd5, ANGLE_LIMIT_RST);
    run_moves(250);
    drain();
    set_config(1'b1, 16'd1, LIMIT_MAX);
    run_moves(180);
    drain();

    // receiver idles less than sender
    send_idle_pct = 55;
    recv_idle_pct = 38;
    set_config(1'b1, 16'($urandom_range(16, 2)), 23'($urandom_range(200000, 1000)));
    run_moves(250);
    drain();
    set_config(1'b0, 16'd3, LIMIT_MAX);
    run_moves(60);
    drain();
    set_config(1'b1, 16'hFFFF, 23'd0);
    run_moves(40);
    drain();

    // no idling; the long receiver hold-off lands in here
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(1'b1, 16'd0, 23'($urandom_range(LIMIT_MAX)));
    run_moves(100);
    drain();
    set_config(1'b1, 16'($urandom_range(10, 1)), 23'($urandom_range(500000)));
    run_moves(400);
    drain();

    if (sb.errors == 0 && sb.expected_setpoints.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
